@@ rtl/bmse_pkg.sv @@
package bmse_pkg;

  typedef enum logic [2:0] {
    REQ_WRITE = 3'd0,
    REQ_READ  = 3'd1,
    REQ_ROW   = 3'd2,
    REQ_COL   = 3'd3,
    REQ_FIND  = 3'd4
  } req_type_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic [0:0] REG_ROWS = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;

  // classified command handed from front to back
  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_ROW,
    CMD_COL,
    CMD_FIND,
    CMD_ERROR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] value;
    logic [8:0]  nr;
    logic [8:0]  nc;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_value;
    logic [3:0]  out_row;
    logic [3:0]  out_col;
    logic        last;
  } res_t;

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic float_equal(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b1;
    return a == b;
  endfunction

endpackage

@@ rtl/bmse_if.sv @@
interface bmse_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] row_index;
  logic [7:0] col_index;
  logic [31:0] value;
  modport source (output valid, req_type, row_index, col_index, value, input ready);
  modport sink (input valid, req_type, row_index, col_index, value, output ready);
endinterface

interface bmse_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] data_value;
  logic [3:0]  out_row;
  logic [3:0]  out_col;
  logic        last;
  modport source (output valid, status, data_value, out_row, out_col, last, input ready);
  modport sink (input valid, status, data_value, out_row, out_col, last, output ready);
endinterface

@@ rtl/bounded_matrix_store_engine.sv @@
// Matrix store of MAX_ROWS x MAX_COLS single-precision words with write, read,
// row/column streaming and first-match search. After reset a clearing pass of
// MAX_ROWS*MAX_COLS entries zeroes the store; at most one request is queued
// during it. A row or column stream issues each read, then takes its word from
// the registered store port, and waits while the output is held; a search
// scans entries in row-major order through that same port. Dimensions are
// written through cfg_we/cfg_index/cfg_data while idle; busy is not a port,
// so wait for the last word before writing.
module bounded_matrix_store_engine #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  bmse_req_if.sink   req,
  bmse_res_if.source res
);
  import bmse_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  bmse_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .req,
    .cmd_valid, .cmd_ready, .cmd
  );

  bmse_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd, .res
  );

endmodule

@@ rtl/bmse_front.sv @@
module bmse_front #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [4:0]    cfg_data,
  bmse_req_if.sink      req,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output bmse_pkg::cmd_t cmd
);
  import bmse_pkg::*;

  localparam logic [8:0] MaxR = 9'(MAX_ROWS);
  localparam logic [8:0] MaxC = 9'(MAX_COLS);

  logic [4:0] rows_in_use;
  logic [4:0] cols_in_use;
  logic [8:0] nr;
  logic [8:0] nc;
  logic       known;
  cmd_t       cls;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 5'd16;
      cols_in_use <= 5'd16;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS) rows_in_use <= cfg_data;
      else cols_in_use <= cfg_data;
    end
  end

  assign nr = (9'(rows_in_use) > MaxR) ? MaxR : 9'(rows_in_use);
  assign nc = (9'(cols_in_use) > MaxC) ? MaxC : 9'(cols_in_use);

  // classify request
  always_comb begin
    cls.row   = req.row_index;
    cls.col   = req.col_index;
    cls.value = req.value;
    cls.nr    = nr;
    cls.nc    = nc;
    cls.op    = CMD_ERROR;
    known     = 1'b1;
    unique case (req.req_type)
      REQ_WRITE, REQ_READ: begin
        if (9'(req.row_index) >= nr || 9'(req.col_index) >= nc) cls.op = CMD_ERROR;
        else cls.op = (req.req_type == REQ_WRITE) ? CMD_WRITE : CMD_READ;
      end
      REQ_ROW: cls.op = (9'(req.row_index) >= nr || nc == 9'd0) ? CMD_ERROR : CMD_ROW;
      REQ_COL: cls.op = (9'(req.col_index) >= nc || nr == 9'd0) ? CMD_ERROR : CMD_COL;
      REQ_FIND: cls.op = CMD_FIND;
      default: known = 1'b0;
    endcase
  end

  // single-entry queue between front and back
  assign req.ready = !rst && (!cmd_valid || cmd_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req.ready) begin
      cmd_valid <= req.valid && known;
    end
    if (req.ready && req.valid) cmd <= cls;
  end

endmodule

@@ rtl/bmse_back.sv @@
module bmse_back #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bmse_pkg::cmd_t cmd,
  bmse_res_if.source     res
);
  import bmse_pkg::*;

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DW = $clog2(Depth + 1);

  typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_ISSUE, S_WAIT, S_EMIT} state_t;

  logic [31:0]   mem [Depth];
  state_t        state;
  cmd_t          c;
  logic [8:0]    i, j;
  logic [DW-1:0] clr;
  logic [31:0]   rdata;
  logic          rd_pend;
  logic [8:0]    pi, pj;
  logic          plast;
  logic          out_full;
  logic          step_ok;
  logic          emit;

  function automatic logic [AW-1:0] addr(input logic [8:0] r, input logic [8:0] cc);
    return AW'(r[RW-1:0] * AW'(MAX_COLS)) + AW'(cc[CW-1:0]);
  endfunction

  assign out_full  = res.valid && !res.ready;
  assign cmd_ready = (state == S_IDLE) && !out_full;
  assign step_ok   = !out_full;

  // a result word is loaded this cycle
  assign emit = (state == S_IDLE && cmd_valid && cmd_ready &&
                 (cmd.op == CMD_WRITE || cmd.op == CMD_ERROR ||
                  (cmd.op == CMD_FIND && (cmd.nr == 9'd0 || cmd.nc == 9'd0)))) ||
                (state == S_EMIT &&
                 ((c.op == CMD_FIND) ? (float_equal(c.value, rdata) || plast) : step_ok));

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) mem[clr[AW-1:0]] <= 32'd0;
    else if (state == S_IDLE && cmd_valid && cmd_ready && cmd.op == CMD_WRITE)
      mem[addr(9'(cmd.row), 9'(cmd.col))] <= cmd.value;
    rdata <= mem[(state == S_IDLE) ? addr(9'(cmd.row), 9'(cmd.col)) : addr(i, j)];
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      res.valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (emit) res.valid <= 1'b1;
      else if (res.ready) res.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == DW'(Depth - 1)) state <= S_IDLE;
        end
        S_IDLE: if (cmd_valid && cmd_ready) begin
          c <= cmd;
          unique case (cmd.op)
            CMD_WRITE, CMD_ERROR: begin
              res.status     <= (cmd.op == CMD_ERROR) ? ST_RANGE : ST_OK;
              res.data_value <= 32'd0;
              res.out_row    <= (cmd.op == CMD_ERROR) ? 4'd0 : cmd.row[3:0];
              res.out_col    <= (cmd.op == CMD_ERROR) ? 4'd0 : cmd.col[3:0];
              res.last       <= 1'b1;
            end
            CMD_READ: begin
              i <= 9'(cmd.row); j <= 9'(cmd.col);
              pi <= 9'(cmd.row); pj <= 9'(cmd.col); plast <= 1'b1;
              state <= S_EMIT;
            end
            CMD_ROW: begin
              i <= 9'(cmd.row); j <= 9'd0; state <= S_ISSUE;
            end
            CMD_COL: begin
              i <= 9'd0; j <= 9'(cmd.col); state <= S_ISSUE;
            end
            CMD_FIND: begin
              i <= 9'd0; j <= 9'd0;
              if (cmd.nr == 9'd0 || cmd.nc == 9'd0) begin
                res.status <= ST_NOTFOUND;
                res.data_value <= 32'd0; res.out_row <= 4'd0;
                res.out_col <= 4'd0; res.last <= 1'b1;
              end else state <= S_ISSUE;
            end
            default: ;
          endcase
        end
        // read issued at (i,j); data arrives next cycle
        S_ISSUE: begin
          pi <= i; pj <= j;
          if (c.op == CMD_READ) begin
            plast <= 1'b1;
          end else if (c.op == CMD_ROW) begin
            plast <= (j + 9'd1 == c.nc); j <= j + 9'd1;
          end else if (c.op == CMD_COL) begin
            plast <= (i + 9'd1 == c.nr); i <= i + 9'd1;
          end else begin
            plast <= (i + 9'd1 == c.nr) && (j + 9'd1 == c.nc);
            if (j + 9'd1 == c.nc) begin j <= 9'd0; i <= i + 9'd1; end
            else j <= j + 9'd1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (c.op == CMD_FIND) begin
            if (float_equal(c.value, rdata)) begin
              res.status <= ST_OK; res.data_value <= 32'd0;
              res.out_row <= pi[3:0]; res.out_col <= pj[3:0]; res.last <= 1'b1;
              state <= S_IDLE;
            end else if (plast) begin
              res.status <= ST_NOTFOUND; res.data_value <= 32'd0;
              res.out_row <= 4'd0; res.out_col <= 4'd0; res.last <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_ISSUE;
            end
          end else if (step_ok) begin
            res.status <= ST_OK; res.data_value <= rdata;
            res.out_row <= pi[3:0]; res.out_col <= pj[3:0]; res.last <= plast;
            state <= plast ? S_IDLE : S_ISSUE;
          end else begin
            state <= S_WAIT;
          end
        end
        // output held: re-read the same entry
        S_WAIT: begin
          i <= pi; j <= pj;
          if (step_ok) state <= S_ISSUE;
          else state <= S_WAIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ verif/bounded_matrix_store_engine_tb.sv @@
`timescale 1ns / 100ps

module bounded_matrix_store_engine_tb;
  import bmse_pkg::*;

  localparam int DIM_MAX = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 18;
  localparam int NUM_PHASES = 8;
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST = 3'd7;
  localparam logic [31:0] POS_ZERO = 32'h0000_0000;
  localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] QUIET_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] r;
    logic [7:0] c;
    logic [31:0] v;
    bit typed;
    res_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [4:0] cfg_data;

  bmse_req_if req_bus();
  bmse_res_if res_bus();

  bounded_matrix_store_engine dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_bus),
    .res(res_bus)
  );

  // predictor state
  logic [31:0] matrix_img [DIM_MAX*DIM_MAX];
  logic [4:0] rows_reg;
  logic [4:0] cols_reg;
  res_t pending_words[$];

  int errors = 0;
  int send_idle_pct;
  int recv_idle_pct;
  int cyc = 0;
  int hold_end;
  int quiet_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit nan_pattern(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic bit same_float(input logic [31:0] a, input logic [31:0] b);
    if (nan_pattern(a) || nan_pattern(b)) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b1;
    return a == b;
  endfunction

  function automatic res_t mk_word(input logic [1:0] st, input logic [31:0] d,
                                   input logic [3:0] r, input logic [3:0] c,
                                   input logic l);
    res_t w;
    w.status = st;
    w.data_value = d;
    w.out_row = r;
    w.out_col = c;
    w.last = l;
    return w;
  endfunction

  // compute the words a request gives and apply its effect on the store image
  function automatic void predict_matrix_op(input logic [2:0] kind, input logic [7:0] r,
                                            input logic [7:0] c, input logic [31:0] v,
                                            ref res_t words[$]);
    int nr;
    int nc;
    bit hit;
    nr = (rows_reg > DIM_MAX) ? DIM_MAX : rows_reg;
    nc = (cols_reg > DIM_MAX) ? DIM_MAX : cols_reg;
    hit = 1'b0;
    case (kind)
      REQ_WRITE, REQ_READ: begin
        if (r >= nr || c >= nc) begin
          words.push_back(mk_word(ST_RANGE, '0, '0, '0, 1'b1));
        end else if (kind == REQ_WRITE) begin
          matrix_img[r*DIM_MAX + c] = v;
          words.push_back(mk_word(ST_OK, '0, r[3:0], c[3:0], 1'b1));
        end else begin
          words.push_back(mk_word(ST_OK, matrix_img[r*DIM_MAX + c], r[3:0], c[3:0], 1'b1));
        end
      end
      REQ_ROW: begin
        if (r >= nr || nc == 0) begin
          words.push_back(mk_word(ST_RANGE, '0, '0, '0, 1'b1));
        end else begin
          for (int j = 0; j < nc; j++)
            words.push_back(mk_word(ST_OK, matrix_img[r*DIM_MAX + j], r[3:0], 4'(j),
                                    j == nc - 1));
        end
      end
      REQ_COL: begin
        if (c >= nc || nr == 0) begin
          words.push_back(mk_word(ST_RANGE, '0, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < nr; i++)
            words.push_back(mk_word(ST_OK, matrix_img[i*DIM_MAX + c], 4'(i), c[3:0],
                                    i == nr - 1));
        end
      end
      REQ_FIND: begin
        for (int i = 0; i < nr && !hit; i++)
          for (int j = 0; j < nc && !hit; j++)
            if (same_float(v, matrix_img[i*DIM_MAX + j])) begin
              words.push_back(mk_word(ST_OK, '0, 4'(i), 4'(j), 1'b1));
              hit = 1'b1;
            end
        if (!hit) words.push_back(mk_word(ST_NOTFOUND, '0, '0, '0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  // offer one word and record its expectation when it is taken
  task automatic send_request(input logic [2:0] kind, input logic [7:0] r,
                              input logic [7:0] c, input logic [31:0] v,
                              input bit typed, input res_t want);
    res_t words[$];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.row_index <= r;
    req_bus.col_index <= c;
    req_bus.value <= v;
    do @(posedge clk); while (!(req_bus.valid && req_bus.ready));
    predict_matrix_op(kind, r, c, v, words);
    if (typed) pending_words.push_back(want);
    else foreach (words[k]) pending_words.push_back(words[k]);
  endtask

  task automatic write_dims(input logic [4:0] nrows, input logic [4:0] ncols);
    cfg_we <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data <= nrows;
    @(posedge clk);
    rows_reg = nrows;
    cfg_index <= REG_COLS;
    cfg_data <= ncols;
    @(posedge clk);
    cols_reg = ncols;
    cfg_we <= 1'b0;
  endtask

  task automatic drain_and_settle();
    req_bus.valid <= 1'b0;
    while (pending_words.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // search key or write data, biased toward signed zeros, nan, inf and stored values
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return POS_ZERO;
      1: return NEG_ZERO;
      2: return {1'($urandom), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      3: return POS_INF;
      4, 5: return matrix_img[$urandom_range(0, DIM_MAX*DIM_MAX - 1)];
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_index();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, DIM_MAX));
  endfunction

  // receiver: readiness and checking of each result word
  always @(posedge clk) begin
    res_t w;
    cyc <= cyc + 1;
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected word st=%0d data=%h row=%0d col=%0d last=%0b", $time,
                   res_bus.status, res_bus.data_value, res_bus.out_row, res_bus.out_col,
                   res_bus.last);
          errors++;
        end else begin
          w = pending_words.pop_front();
          if (res_bus.status !== w.status || res_bus.data_value !== w.data_value ||
              res_bus.out_row !== w.out_row || res_bus.out_col !== w.out_col ||
              res_bus.last !== w.last) begin
            $display("%0t: expected st=%0d data=%h row=%0d col=%0d last=%0b, got st=%0d data=%h row=%0d col=%0d last=%0b",
                     $time, w.status, w.data_value, w.out_row, w.out_col, w.last,
                     res_bus.status, res_bus.data_value, res_bus.out_row, res_bus.out_col,
                     res_bus.last);
            errors++;
          end
        end
      end
      if (cyc < hold_end) res_bus.ready <= 1'b0;
      else res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t plan[$];
    logic [4:0] phase_rows [NUM_PHASES];
    logic [4:0] phase_cols [NUM_PHASES];
    res_t none;
    logic [2:0] kind;

    none = mk_word('0, '0, '0, '0, 1'b0);
    hold_end = 0;
    send_idle_pct = 16;
    recv_idle_pct = 85;
    rows_reg = 5'd16;
    cols_reg = 5'd16;
    foreach (matrix_img[k]) matrix_img[k] = '0;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_ROWS;
    cfg_data <= '0;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= REQ_WRITE;
    req_bus.row_index <= '0;
    req_bus.col_index <= '0;
    req_bus.value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset contents, corners, signed zero, nan, range errors, spare types
    plan = '{
      '{REQ_READ, 8'd0, 8'd0, ALL_ONES, 1'b1, mk_word(ST_OK, '0, 4'd0, 4'd0, 1'b1)},
      '{REQ_WRITE, 8'd15, 8'd15, ALL_ONES, 1'b1, mk_word(ST_OK, '0, 4'd15, 4'd15, 1'b1)},
      '{REQ_READ, 8'd15, 8'd15, POS_ZERO, 1'b1, mk_word(ST_OK, ALL_ONES, 4'd15, 4'd15, 1'b1)},
      '{REQ_WRITE, 8'd16, 8'd0, ALL_ONES, 1'b1, mk_word(ST_RANGE, '0, '0, '0, 1'b1)},
      '{REQ_READ, 8'd0, 8'd255, POS_ZERO, 1'b1, mk_word(ST_RANGE, '0, '0, '0, 1'b1)},
      '{REQ_WRITE, 8'd255, 8'd255, ALL_ONES, 1'b1, mk_word(ST_RANGE, '0, '0, '0, 1'b1)},
      '{REQ_WRITE, 8'd3, 8'd4, NEG_ZERO, 1'b1, mk_word(ST_OK, '0, 4'd3, 4'd4, 1'b1)},
      '{REQ_FIND, 8'd0, 8'd0, POS_ZERO, 1'b1, mk_word(ST_OK, '0, 4'd0, 4'd0, 1'b1)},
      '{REQ_WRITE, 8'd0, 8'd0, QUIET_NAN, 1'b1, mk_word(ST_OK, '0, 4'd0, 4'd0, 1'b1)},
      '{REQ_FIND, 8'd0, 8'd0, NEG_ZERO, 1'b0, none},
      '{REQ_FIND, 8'd0, 8'd0, QUIET_NAN, 1'b1, mk_word(ST_NOTFOUND, '0, '0, '0, 1'b1)},
      '{REQ_FIND, 8'd0, 8'd0, 32'h1234_5678, 1'b1, mk_word(ST_NOTFOUND, '0, '0, '0, 1'b1)},
      '{REQ_WRITE, 8'd0, 8'd1, POS_INF, 1'b0, none},
      '{REQ_FIND, 8'd9, 8'd9, POS_INF, 1'b0, none},
      '{REQ_ROW, 8'd15, 8'd0, POS_ZERO, 1'b0, none},
      '{REQ_ROW, 8'd0, 8'd7, POS_ZERO, 1'b0, none},
      '{REQ_COL, 8'd0, 8'd4, POS_ZERO, 1'b0, none},
      '{REQ_COL, 8'd0, 8'd15, POS_ZERO, 1'b0, none},
      '{REQ_ROW, 8'd16, 8'd0, POS_ZERO, 1'b1, mk_word(ST_RANGE, '0, '0, '0, 1'b1)},
      '{REQ_COL, 8'd0, 8'd16, POS_ZERO, 1'b1, mk_word(ST_RANGE, '0, '0, '0, 1'b1)},
      '{REQ_SPARE_FIRST, 8'd1, 8'd1, ALL_ONES, 1'b0, none},
      '{REQ_SPARE_LAST, 8'd2, 8'd2, ALL_ONES, 1'b0, none},
      '{REQ_READ, 8'd2, 8'd2, POS_ZERO, 1'b0, none}
    };
    foreach (plan[k])
      send_request(plan[k].kind, plan[k].r, plan[k].c, plan[k].v, plan[k].typed,
                   plan[k].want);
    drain_and_settle();

    // random phases over dimension settings, including oversize, one and zero
    phase_rows = '{5'd31, 5'd1, 5'd0, 5'd5, 5'd16, 5'd3, 5'd12, 5'd16};
    phase_cols = '{5'd31, 5'd1, 5'd5, 5'd0, 5'd1, 5'd16, 5'd7, 5'd16};
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 85;
      end else if (p < 6) begin
        send_idle_pct = 85;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_dims(phase_rows[p], phase_cols[p]);
      // long receiver hold-off so the block backs up onto its input
      if (p == 6) hold_end = cyc + HOLD_CYCLES;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST))
                                            : 3'($urandom_range(REQ_WRITE, REQ_FIND));
        send_request(kind, pick_index(), pick_index(), pick_value(), 1'b0, none);
      end
      drain_and_settle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
